// ----- src/oale_pkg.sv -----
// Package for the ordered array list engine: operation and status codes,
// and the control word that the engine hands to each list cell. No dependencies.
`default_nettype none

package oale_pkg;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_FIND   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_POS   = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   localparam int unsigned FIELD_WIDTH = 6;
   localparam int unsigned VALUE_WIDTH = 32;

   // Per-cell command word.
   typedef struct packed {
      logic load;    // take the new value
      logic up;      // take the left neighbor's word
      logic down;    // take the right neighbor's word
      logic sample;  // refresh the match flag
      logic look;    // cell is occupied and a find is running
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- src/oale_if.sv -----
// Valid/ready channels of the ordered array list engine: request and response.
// Depends on oale_pkg for field widths.
`default_nettype none

interface oale_req_if;
   import oale_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    mode;
   logic [FIELD_WIDTH-1:0]        position;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, mode, position, value, input ready);
   modport sink   (input valid, mode, position, value, output ready);
endinterface

interface oale_rsp_if;
   import oale_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             status;
   logic [FIELD_WIDTH-1:0] found_position;
   logic [FIELD_WIDTH-1:0] entry_count;

   modport source (output valid, status, found_position, entry_count, input ready);
   modport sink   (input valid, status, found_position, entry_count, output ready);
endinterface

`default_nettype wire

// ----- src/ordered_array_list_engine_unit.sv -----
// Ordered list of up to CAPACITY signed words at positions 1..count, kept in a
// row of cells that shift up on insert and down on delete, all together;
// find compares every occupied cell at once and takes the lowest match. For
// each request beat the cells update at the accept edge, the engine moves to
// ST_RESOLVE, and the response register is loaded from there once an earlier
// response beat is no longer waiting. A new request is taken only once the
// response is loaded. Cell contents are undefined until written; positions
// above count are never looked at. Depends on oale_pkg, oale_if, oale_cell
// and oale_pick.
`default_nettype none

module ordered_array_list_engine_unit #(
   parameter int unsigned CAPACITY   = 32,
   parameter int unsigned DATA_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   oale_req_if.sink   req_bus,
   oale_rsp_if.source rsp_bus
);
   import oale_pkg::*;

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = $clog2(CAPACITY);
   localparam int unsigned PW = ((CW > FIELD_WIDTH) ? CW : FIELD_WIDTH) + 1;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'b01,
      ST_RESOLVE = 2'b10
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   status_type      status_ff, status_in;
   logic            find_ff, find_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [FIELD_WIDTH-1:0]  rsp_found_ff, rsp_found_in;
   logic [FIELD_WIDTH-1:0]  rsp_count_ff, rsp_count_in;

   logic                    accept;
   logic [PW-1:0]           pos_x, cnt_x;
   logic [DATA_WIDTH-1:0]   value_w;
   logic [VALUE_WIDTH+63:0] value_ext;
   logic                    is_ins, is_del, is_find;
   logic                    ins_ok, del_ok;

   cell_ctl_type            ctl [CAPACITY];
   logic [DATA_WIDTH-1:0]   words [CAPACITY];
   logic [CAPACITY-1:0]     match_bits;
   logic                    hit;
   logic [IW-1:0]           hit_index;
   logic [CW-1:0]           found_pos;
   logic [CW+FIELD_WIDTH-1:0] found_wide, count_wide;
   logic                    slot_free;

   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   assign pos_x     = {{(PW-FIELD_WIDTH){1'b0}}, req_bus.position};
   assign cnt_x     = {{(PW-CW){1'b0}}, count_ff};
   assign value_ext = {{64{req_bus.value[VALUE_WIDTH-1]}}, req_bus.value};
   assign value_w   = value_ext[DATA_WIDTH-1:0];

   assign is_ins  = (req_bus.mode == MODE_INSERT);
   assign is_del  = (req_bus.mode == MODE_DELETE);
   assign is_find = (req_bus.mode == MODE_FIND);
   assign ins_ok  = is_ins && (pos_x != '0) && (pos_x <= cnt_x + PW'(1))
                    && (cnt_x != PW'(CAPACITY));
   assign del_ok  = is_del && (pos_x != '0) && (pos_x <= cnt_x);

   always_comb begin
      status_in = status_ff;
      find_in   = find_ff;
      count_in  = count_ff;
      if (accept) begin
         find_in = is_find;
         case (req_bus.mode)
            MODE_INSERT: begin
               if ((pos_x == '0) || (pos_x > cnt_x + PW'(1))) begin
                  status_in = STATUS_BAD_POS;
               end else if (cnt_x == PW'(CAPACITY)) begin
                  status_in = STATUS_FULL;
               end else begin
                  status_in = STATUS_OK;
                  count_in  = count_ff + CW'(1);
               end
            end
            MODE_DELETE: begin
               if (del_ok) begin
                  status_in = STATUS_OK;
                  count_in  = count_ff - CW'(1);
               end else begin
                  status_in = STATUS_BAD_POS;
               end
            end
            MODE_FIND: status_in = STATUS_NOT_FOUND;
            default:   status_in = STATUS_BAD_POS;
         endcase
      end
   end

   // Cell row: each cell decodes its own move from position and count.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [PW-1:0] IX = PW'(i);
      logic [DATA_WIDTH-1:0] left_word, right_word;

      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_inner_l
         assign left_word = words[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_inner_r
         assign right_word = words[i+1];
      end

      assign ctl[i].load   = accept && ins_ok && (IX + PW'(1) == pos_x);
      assign ctl[i].up     = accept && ins_ok && (IX >= pos_x) && (IX <= cnt_x);
      assign ctl[i].down   = accept && del_ok && (IX + PW'(1) >= pos_x)
                             && (IX + PW'(1) < cnt_x);
      assign ctl[i].sample = accept;
      assign ctl[i].look   = is_find && (IX < cnt_x);

      oale_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl[i]),
         .value      (value_w),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (words[i]),
         .match      (match_bits[i])
      );
   end

   oale_pick #(
      .CAPACITY (CAPACITY)
   ) u_pick (
      .match_bits (match_bits),
      .hit        (hit),
      .index      (hit_index)
   );

   assign found_pos  = CW'({1'b0, hit_index} + (IW+1)'(1));
   assign found_wide = {{FIELD_WIDTH{1'b0}}, found_pos};
   assign count_wide = {{FIELD_WIDTH{1'b0}}, count_ff};
   assign slot_free  = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            // hold until the response slot drains
            if (slot_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_count_in  = count_wide[FIELD_WIDTH-1:0];
               rsp_found_in  = '0;
               rsp_status_in = status_ff;
               if (find_ff && hit) begin
                  rsp_status_in = STATUS_OK;
                  rsp_found_in  = found_wide[FIELD_WIDTH-1:0];
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      find_ff       <= find_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.found_position = rsp_found_ff;
   assign rsp_bus.entry_count    = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_resolves: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RESOLVE))
      else $error("accepted beat did not move to resolve");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && ins_ok |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      accept && del_ok |=> count_ff == $past(count_ff) - CW'(1))
      else $error("delete did not shrink the list");

   a_one_move: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl[0].load, ctl[0].up, ctl[0].down}))
      else $error("first cell given conflicting moves");

endmodule

`default_nettype wire

// ----- src/oale_cell.sv -----
// One list cell: holds one word, shifts to or from its neighbors, compares
// against the search key. Depends on oale_pkg for the cell command word.
`default_nettype none

module oale_cell #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire oale_pkg::cell_ctl_type   ctl,
   input  wire logic [DATA_WIDTH-1:0]    value,
   input  wire logic [DATA_WIDTH-1:0]    left_word,
   input  wire logic [DATA_WIDTH-1:0]    right_word,
   output logic      [DATA_WIDTH-1:0]    word,
   output logic                          match
);
   import oale_pkg::*;

   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic                  match_ff, match_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.load) begin
         word_in = value;
      end else if (ctl.up) begin
         word_in = left_word;
      end else if (ctl.down) begin
         word_in = right_word;
      end
      match_in = match_ff;
      if (ctl.sample) begin
         match_in = ctl.look && (word_ff == value);
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign word  = word_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

// ----- src/oale_pick.sv -----
// Lowest-set-bit finder over the cell match flags; gives hit and index.
// No package dependencies.
`default_nettype none

module oale_pick #(
   parameter int unsigned CAPACITY = 32
) (
   input  wire logic [CAPACITY-1:0]         match_bits,
   output logic                             hit,
   output logic [$clog2(CAPACITY)-1:0]      index
);
   localparam int unsigned IW = $clog2(CAPACITY);

   always_comb begin
      index = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match_bits[i]) begin
            index = IW'(i);
         end
      end
   end

   assign hit = |match_bits;

endmodule

`default_nettype wire
